[sv/double_ended_queue_assert.svh]
// Assertion macros used by the queue datapath (deq_dpath).
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DEQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/deq_pkg.sv]
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        RES_DONE  = 2'd0,
        RES_EMPTY = 2'd1,
        RES_FULL  = 2'd2
    } res_t;

    typedef struct packed {
        logic [7:0]  status;
        logic [15:0] arrival;
        logic [15:0] service;
        logic [15:0] start;
        logic [15:0] finish;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic {
        ST_IDLE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic exec;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;
    } sts_t;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        idx_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        idx_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

endpackage

[sv/deq_ram.sv]
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/deq_ctrl.sv]
module deq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  deq_pkg::sts_t sts,
    output deq_pkg::cmd_t cmd
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.exec = in_valid;
                if (in_valid)
                begin
                    state_next = deq_pkg::ST_DONE;
                end
            end
            deq_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = deq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/deq_dpath.sv]
`include "double_ended_queue_assert.svh"

module deq_dpath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  deq_pkg::cmd_t             cmd,
    output deq_pkg::sts_t             sts,
    input  logic [2:0]                opcode,
    input  deq_pkg::rec_t             in_rec,
    output logic                      ram_we,
    output logic [deq_pkg::IDX_W-1:0] ram_waddr,
    output deq_pkg::rec_t             ram_wdata,
    output logic                      ram_re,
    output logic [deq_pkg::IDX_W-1:0] ram_raddr,
    input  deq_pkg::rec_t             ram_rdata,
    output logic                      out_valid,
    input  logic                      out_ready,
    output deq_pkg::res_t             out_code,
    output deq_pkg::rec_t             out_rec,
    output logic [deq_pkg::CNT_W-1:0] out_count
);

    logic [deq_pkg::IDX_W-1:0] front_reg;
    logic [deq_pkg::IDX_W-1:0] front_next;
    logic [deq_pkg::IDX_W-1:0] rear_reg;
    logic [deq_pkg::IDX_W-1:0] rear_next;
    logic [deq_pkg::CNT_W-1:0] count_reg;
    logic [deq_pkg::CNT_W-1:0] count_next;
    deq_pkg::res_t             code_reg;
    deq_pkg::res_t             code_next;
    logic                      rec_sel_reg;
    logic                      rec_sel_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    deq_pkg::res_t             out_code_reg;
    deq_pkg::rec_t             out_rec_reg;
    logic [deq_pkg::CNT_W-1:0] out_count_reg;
    logic                      is_full;
    logic                      is_empty;

    assign is_full   = (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);
    assign ram_wdata = in_rec;

    always_comb
    begin
        front_next   = front_reg;
        rear_next    = rear_reg;
        count_next   = count_reg;
        code_next    = code_reg;
        rec_sel_next = rec_sel_reg;
        ram_we       = 1'b0;
        ram_waddr    = rear_reg;
        ram_re       = 1'b0;
        ram_raddr    = front_reg;
        if (cmd.exec)
        begin
            code_next    = deq_pkg::RES_DONE;
            rec_sel_next = 1'b0;
            unique case (deq_pkg::op_t'(opcode))
                deq_pkg::OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        code_next = deq_pkg::RES_FULL;
                    end
                    else
                    begin
                        front_next = deq_pkg::idx_prev(front_reg);
                        ram_waddr  = deq_pkg::idx_prev(front_reg);
                        ram_we     = 1'b1;
                        count_next = count_reg + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::OP_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        code_next = deq_pkg::RES_FULL;
                    end
                    else
                    begin
                        rear_next  = deq_pkg::idx_next(rear_reg);
                        ram_waddr  = rear_reg;
                        ram_we     = 1'b1;
                        count_next = count_reg + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        code_next = deq_pkg::RES_EMPTY;
                    end
                    else
                    begin
                        ram_raddr    = front_reg;
                        ram_re       = 1'b1;
                        rec_sel_next = 1'b1;
                        front_next   = deq_pkg::idx_next(front_reg);
                        count_next   = count_reg - deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::OP_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        code_next = deq_pkg::RES_EMPTY;
                    end
                    else
                    begin
                        ram_raddr    = deq_pkg::idx_prev(rear_reg);
                        ram_re       = 1'b1;
                        rec_sel_next = 1'b1;
                        rear_next    = deq_pkg::idx_prev(rear_reg);
                        count_next   = count_reg - deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::OP_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        code_next = deq_pkg::RES_EMPTY;
                    end
                    else
                    begin
                        ram_raddr    = front_reg;
                        ram_re       = 1'b1;
                        rec_sel_next = 1'b1;
                    end
                end
                deq_pkg::OP_PEEK_REAR:
                begin
                    if (is_empty)
                    begin
                        code_next = deq_pkg::RES_EMPTY;
                    end
                    else
                    begin
                        ram_raddr    = deq_pkg::idx_prev(rear_reg);
                        ram_re       = 1'b1;
                        rec_sel_next = 1'b1;
                    end
                end
                default:
                begin
                    // unused opcode: drop the transaction, report done
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        rec_sel_reg <= rec_sel_next;
        if (cmd.load_out)
        begin
            out_code_reg  <= code_reg;
            out_rec_reg   <= rec_sel_reg ? ram_rdata : '0;
            out_count_reg <= count_reg;
        end
    end

    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign out_code     = out_code_reg;
    assign out_rec      = out_rec_reg;
    assign out_count    = out_count_reg;

    `DEQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= deq_pkg::CNT_W'(deq_pkg::DEPTH), "count above depth")
    `DEQ_ASSERT_IMP(a_ring_empty, is_empty, front_reg == rear_reg, "empty ring with split indices")
    `DEQ_ASSERT_IMP(a_one_port, 1'b1, !(ram_we && ram_re), "write and read in one cycle")
    `DEQ_ASSERT_IMP(a_load_free, cmd.load_out, !(out_valid_reg && !out_ready), "result overwritten")
    `DEQ_ASSERT_NEXT(a_push_count, ram_we, count_reg == $past(count_reg) + deq_pkg::CNT_W'(1), "push count")

endmodule

[sv/double_ended_queue.sv]
// Bounded double-ended queue of customer records held in a ring of deq_pkg::DEPTH slots
// in one RAM. Every transaction carries one of six operations (push/pop/peek at either
// end) and yields exactly one result: a code (done, empty, full), the record popped or
// peeked (zero otherwise) and the count after the operation. An accepted transaction
// updates the ring indices and accesses the RAM in its accept cycle; in ST_DONE the
// registered RAM data goes to the output register once it is free; in_ready is low
// there, so a new transaction waits, owing to the registered read port of the record
// RAM. The output register lets a result wait for out_ready while the next transaction
// is taken. No clearing pass: slots are read only after they were written.
module double_ended_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                opcode,
    input  logic [7:0]                cust_status,
    input  logic [15:0]               arrival_time,
    input  logic [15:0]               service_time,
    input  logic [15:0]               start_time,
    input  logic [15:0]               end_time,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                result_code,
    output logic [7:0]                out_status,
    output logic [15:0]               out_arrival,
    output logic [15:0]               out_service,
    output logic [15:0]               out_start,
    output logic [15:0]               out_end,
    output logic [deq_pkg::CNT_W-1:0] entries_now
);

    deq_pkg::cmd_t             cmd;
    deq_pkg::sts_t             sts;
    deq_pkg::rec_t             in_rec;
    deq_pkg::rec_t             out_rec;
    deq_pkg::res_t             out_code;
    logic                      ram_we;
    logic [deq_pkg::IDX_W-1:0] ram_waddr;
    deq_pkg::rec_t             ram_wdata;
    logic                      ram_re;
    logic [deq_pkg::IDX_W-1:0] ram_raddr;
    logic [deq_pkg::REC_W-1:0] ram_rdata;

    assign in_rec.status  = cust_status;
    assign in_rec.arrival = arrival_time;
    assign in_rec.service = service_time;
    assign in_rec.start   = start_time;
    assign in_rec.finish  = end_time;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    deq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (opcode),
        .in_rec    (in_rec),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (deq_pkg::rec_t'(ram_rdata)),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_code  (out_code),
        .out_rec   (out_rec),
        .out_count (entries_now)
    );

    deq_ram #(
        .WIDTH (deq_pkg::REC_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result_code = out_code;
    assign out_status  = out_rec.status;
    assign out_arrival = out_rec.arrival;
    assign out_service = out_rec.service;
    assign out_start   = out_rec.start;
    assign out_end     = out_rec.finish;

endmodule

[tb/tb_double_ended_queue.sv]
`timescale 1ns / 100ps

module tb_double_ended_queue;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_OPS = 2000;
    localparam int SEGMENT_OPS = 40;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        deq_pkg::res_t             code;
        deq_pkg::rec_t             rec;
        logic [deq_pkg::CNT_W-1:0] count;
    } deq_result_t;

    // Ring mirror of the queue and the results still owed by the block
    class deque_tracker;
        deq_pkg::rec_t ring[deq_pkg::DEPTH];
        int            front;
        int            rear;
        int            count;
        int            errors;
        deq_result_t   awaited[$];

        function new();
            front = 0;
            rear = 0;
            count = 0;
            errors = 0;
        endfunction

        function void apply_op(logic [2:0] op, deq_pkg::rec_t rec);
            deq_result_t r;
            r.code = deq_pkg::RES_DONE;
            r.rec = '0;
            case (op) inside
                deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR:
                    if (count == deq_pkg::DEPTH)
                    begin
                        r.code = deq_pkg::RES_FULL;
                    end
                    else if (op == deq_pkg::OP_PUSH_FRONT)
                    begin
                        front = (front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                        ring[front] = rec;
                        count++;
                    end
                    else
                    begin
                        ring[rear] = rec;
                        rear = (rear + 1) % deq_pkg::DEPTH;
                        count++;
                    end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR,
                deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_REAR:
                    if (count == 0)
                    begin
                        r.code = deq_pkg::RES_EMPTY;
                    end
                    else if (op == deq_pkg::OP_POP_FRONT)
                    begin
                        r.rec = ring[front];
                        front = (front + 1) % deq_pkg::DEPTH;
                        count--;
                    end
                    else if (op == deq_pkg::OP_POP_REAR)
                    begin
                        rear = (rear + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                        r.rec = ring[rear];
                        count--;
                    end
                    else if (op == deq_pkg::OP_PEEK_FRONT)
                    begin
                        r.rec = ring[front];
                    end
                    else
                    begin
                        r.rec = ring[(rear + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH];
                    end
                default: ;  // spare opcodes leave the queue alone
            endcase
            r.count = deq_pkg::CNT_W'(count);
            awaited.push_back(r);
        endfunction

        function void check_field(string name, logic [15:0] exp, logic [15:0] act);
            if (act !== exp)
            begin
                $error("%s: expected %0h, got %0h", name, exp, act);
                errors++;
            end
        endfunction

        function void match_result(logic [1:0] code, deq_pkg::rec_t got,
                                   logic [deq_pkg::CNT_W-1:0] cnt);
            deq_result_t e;
            if (awaited.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = awaited.pop_front();
            check_field("result_code", 16'(e.code), 16'(code));
            check_field("out_status", 16'(e.rec.status), 16'(got.status));
            check_field("out_arrival", e.rec.arrival, got.arrival);
            check_field("out_service", e.rec.service, got.service);
            check_field("out_start", e.rec.start, got.start);
            check_field("out_end", e.rec.finish, got.finish);
            check_field("entries_now", 16'(e.count), 16'(cnt));
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [2:0]                opcode;
    logic [7:0]                cust_status;
    logic [15:0]               arrival_time;
    logic [15:0]               service_time;
    logic [15:0]               start_time;
    logic [15:0]               end_time;
    logic                      out_valid;
    logic                      out_ready;
    logic [1:0]                result_code;
    logic [7:0]                out_status;
    logic [15:0]               out_arrival;
    logic [15:0]               out_service;
    logic [15:0]               out_start;
    logic [15:0]               out_end;
    logic [deq_pkg::CNT_W-1:0] entries_now;

    int                  send_idle_pct = 17;
    int                  recv_idle_pct = 55;
    int                  cycle_count = 0;
    deque_tracker        tracker = new();

    double_ended_queue u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .cust_status  (cust_status),
        .arrival_time (arrival_time),
        .service_time (service_time),
        .start_time   (start_time),
        .end_time     (end_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_code  (result_code),
        .out_status   (out_status),
        .out_arrival  (out_arrival),
        .out_service  (out_service),
        .out_start    (out_start),
        .out_end      (out_end),
        .entries_now  (entries_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL double_ended_queue");
        $finish;
    end

    // Check each result transaction, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_result(result_code,
                                 {out_status, out_arrival, out_service, out_start, out_end},
                                 entries_now);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic deq_pkg::rec_t rand_rec();
        deq_pkg::rec_t r;
        r.status = 8'($urandom);
        r.arrival = 16'($urandom);
        r.service = 16'($urandom);
        r.start = 16'($urandom);
        r.finish = 16'($urandom);
        return r;
    endfunction

    task automatic send_op(input logic [2:0] op, input deq_pkg::rec_t rec);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        cust_status <= rec.status;
        arrival_time <= rec.arrival;
        service_time <= rec.service;
        start_time <= rec.start;
        end_time <= rec.finish;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.apply_op(op, rec);
    endtask

    task automatic send_random_op(input int push_pct);
        int          roll;
        logic [2:0]  op;
        roll = $urandom_range(99);
        if (roll < 2)
            op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
        else if (roll < push_pct)
            op = $urandom_range(1) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT;
        else if ($urandom_range(99) < 60)
            op = $urandom_range(1) ? deq_pkg::OP_POP_REAR : deq_pkg::OP_POP_FRONT;
        else
            op = $urandom_range(1) ? deq_pkg::OP_PEEK_REAR : deq_pkg::OP_PEEK_FRONT;
        send_op(op, rand_rec());
    endtask

    initial
    begin
        int             push_pct;
        deq_pkg::rec_t  rec;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        out_ready <= 1'b0;
        opcode <= deq_pkg::OP_PUSH_FRONT;
        cust_status <= '0;
        arrival_time <= '0;
        service_time <= '0;
        start_time <= '0;
        end_time <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: every read reports empty, spare opcodes do nothing
        send_op(deq_pkg::OP_POP_FRONT, rand_rec());
        send_op(deq_pkg::OP_POP_REAR, rand_rec());
        send_op(deq_pkg::OP_PEEK_FRONT, rand_rec());
        send_op(deq_pkg::OP_PEEK_REAR, rand_rec());
        send_op(OP_SPARE_6, rand_rec());
        send_op(OP_SPARE_7, '1);

        // Fill from both ends, extremes first, then push against the full ring and peek and pop from it
        for (int i = 0; i < deq_pkg::DEPTH; i++)
        begin
            if (i == 0)
                rec = '1;
            else if (i == 1)
                rec = '0;
            else
                rec = rand_rec();
            send_op((i % 2 == 0) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_REAR, rec);
        end
        send_op(deq_pkg::OP_PUSH_FRONT, rand_rec());
        send_op(deq_pkg::OP_PUSH_REAR, rand_rec());
        send_op(deq_pkg::OP_PEEK_FRONT, rand_rec());
        send_op(deq_pkg::OP_PEEK_REAR, rand_rec());
        send_op(deq_pkg::OP_POP_FRONT, rand_rec());
        send_op(deq_pkg::OP_POP_REAR, rand_rec());

        // Random part: push bias moves per segment so the ring swings full and empty
        push_pct = 50;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == RANDOM_OPS / 3)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 17;
            end
            else if (n == 2 * RANDOM_OPS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n % SEGMENT_OPS == 0)
                push_pct = 10 + 20 * $urandom_range(4);
            send_random_op(push_pct);
        end
        in_valid <= 1'b0;

        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (tracker.errors == 0)
            $display("PASS double_ended_queue");
        else
            $display("FAIL double_ended_queue");
        $finish;
    end

endmodule
